// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules; lkv_dp includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`endif
`endif

// ===== hw/rtl/lkv_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
package lkv_pkg;

   localparam int LKV_ENTRIES_DEFAULT = 16;
   localparam int LKV_CAP_W           = 5;
   localparam logic [LKV_CAP_W-1:0] LKV_CAP_RESET = 5'd16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic touch;
      logic rd_issue;
      logic wr_hit;
      logic evict;
      logic insert;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic is_put;
      logic need_evict;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== hw/rtl/lkv_ctrl.sv =====
// Sequencing state machine of the LRU key-value cache.
module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_INSERT = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            if (sts.hit) begin
               cmd.touch    = 1'b1;
               cmd.rd_issue = !sts.is_put;
               cmd.wr_hit   = sts.is_put;
               state_in     = S_FIN;
            end else if (sts.is_put) begin
               // make room first, the insert sees the freed slot
               cmd.evict = sts.need_evict;
               state_in  = S_INSERT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lkv_dp.sv =====
// Entry store, recency ranks and result register of the LRU key-value cache.
`include "assert_macros.svh"
module lkv_dp
   import lkv_pkg::*;
#(
   parameter int ENTRIES = LKV_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [LKV_CAP_W-1:0] capacity,
   input  req_type              req_data,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int EC_W   = (OCC_W > LKV_CAP_W) ? OCC_W : LKV_CAP_W;

   req_type                 req_ff;
   logic signed [31:0]      key_ff [ENTRIES];
   logic [31:0]             data_mem [ENTRIES];
   logic [31:0]             rd_data_ff;
   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [RANK_W-1:0]       rank_ff [ENTRIES];
   logic [RANK_W-1:0]       rank_in [ENTRIES];
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [ENTRIES-1:0]      match_oh_ff, victim_oh_ff;
   logic                    hit_ff, need_evict_ff;
   logic [RANK_W-1:0]       hit_rank_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic [ENTRIES-1:0]      match_oh, victim_oh, free_oh, invalid;
   logic [RANK_W-1:0]       hit_rank;
   logic [OCC_W-1:0]        occ_m1;
   logic [EC_W-1:0]         eff_cap;
   logic                    need_evict;
   logic [IDX_W-1:0]        hit_idx, free_idx, mem_waddr;
   logic                    mem_we;

   // clamp capacity to 1..ENTRIES
   always_comb begin
      eff_cap = EC_W'(capacity);
      if (capacity == '0) begin
         eff_cap = EC_W'(1);
      end else if (EC_W'(capacity) > EC_W'(ENTRIES)) begin
         eff_cap = EC_W'(ENTRIES);
      end
   end

   assign need_evict = EC_W'(occ_ff) >= eff_cap;
   assign occ_m1     = occ_ff - OCC_W'(1);

   // ranks of valid entries always form 0..occ-1, so the oldest has rank occ-1
   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_oh[i]  = valid_ff[i] && (key_ff[i] == req_ff.key);
         victim_oh[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_m1);
         hit_rank     = hit_rank | (match_oh[i] ? rank_ff[i] : '0);
      end
   end

   // lowest free slot
   assign invalid = ~valid_ff;
   assign free_oh = invalid & (~invalid + ENTRIES'(1));

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_idx  = hit_idx  | (match_oh_ff[i] ? IDX_W'(i) : '0);
         free_idx = free_idx | (free_oh[i]     ? IDX_W'(i) : '0);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.touch) begin
            if (match_oh_ff[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         if (cmd.evict && victim_oh_ff[i]) begin
            rank_in[i] = '0;
         end
         if (cmd.insert) begin
            if (free_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      if (cmd.evict) begin
         valid_in = valid_ff & ~victim_oh_ff;
         occ_in   = occ_ff - OCC_W'(1);
      end
      if (cmd.insert) begin
         valid_in = valid_ff | free_oh;
         occ_in   = occ_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         occ_ff        <= '0;
         match_oh_ff   <= '0;
         victim_oh_ff  <= '0;
         hit_ff        <= 1'b0;
         need_evict_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (cmd.lookup) begin
            match_oh_ff   <= match_oh;
            victim_oh_ff  <= victim_oh;
            hit_ff        <= |match_oh;
            need_evict_ff <= need_evict;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.lookup) begin
         hit_rank_ff <= hit_rank;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.insert && free_oh[i]) begin
            key_ff[i] <= req_ff.key;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.hit        <= hit_ff;
         rsp_ff.read_value <= (hit_ff && (req_ff.func == FUNC_GET)) ? rd_data_ff : '0;
      end
   end

   // value store: one write port, one registered read port
   assign mem_we    = cmd.wr_hit || cmd.insert;
   assign mem_waddr = cmd.wr_hit ? hit_idx : free_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_waddr] <= req_ff.value;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= data_mem[hit_idx];
      end
   end

   assign sts.hit        = hit_ff;
   assign sts.is_put     = (req_ff.func == FUNC_PUT);
   assign sts.need_evict = need_evict_ff;
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_occ_matches_valid, clock, reset, $countones(valid_ff) == int'(occ_ff))
   `ASSERT_ALWAYS(a_occ_in_range, clock, reset, int'(occ_ff) <= ENTRIES)
   `ASSERT_ALWAYS(a_keys_unique, clock, reset, $onehot0(match_oh_ff))
   `ASSERT_IMPLY(a_victim_found, clock, reset, need_evict_ff, $onehot(victim_oh_ff))
   `ASSERT_IMPLY(a_insert_has_room, clock, reset, cmd.insert, $onehot(free_oh))

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// LRU key-value cache top level: capacity register, controller and datapath.
// Sequence: the controller steps through capture, lookup, update, optional insert and
// result load, and rsp_valid is registered from the result load; a new request is taken
// only after the sequence of the last one is done. A result still waiting under
// rsp_stall holds the next result load, and the req side stalls until it leaves.
// Reset: synchronous; store empty, all ranks zero, capacity register reads 16.
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = LKV_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LKV_CAP_W-1:0] capacity_ff;
   logic                 csr_write;
   logic                 csr_index;
   cmd_type              cmd;
   sts_type              sts;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= LKV_CAP_RESET;
      end else if (csr_write && (csr_index == REG_CAPACITY)) begin
         capacity_ff <= csr_pwdata[LKV_CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_index == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lkv_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
